// ----- rtl/superchip8_instruction_core_top_macros.svh -----
// Assertion macros for the instruction core.
`ifndef SUPERCHIP8_INSTRUCTION_CORE_TOP_MACROS_SVH
`define SUPERCHIP8_INSTRUCTION_CORE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define SC8_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define SC8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SC8_ASSERT_NOW(lbl, ante, cons, msg)
`define SC8_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/sc8_pkg.sv -----
package sc8_pkg;

	localparam int MEM_BYTES      = 4096;
	localparam int STACK_DEPTH    = 16;
	localparam int SCREEN_COLUMNS = 128;
	localparam int SCREEN_ROWS    = 64;
	localparam int FLAG_SLOTS     = 8;
	localparam int PROGRAM_START  = 512;
	localparam int GLYPH_BYTES    = 180;
	localparam int COL_W          = $clog2(SCREEN_COLUMNS);

	// operation codes carried in tuser
	typedef enum logic [2:0] {
		OPER_LOAD   = 3'd0,
		OPER_READ   = 3'd1,
		OPER_EXEC   = 3'd2,
		OPER_TICK   = 3'd3,
		OPER_KEY    = 3'd4,
		OPER_COLUMN = 3'd5
	} oper_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_OPER, ST_RDWAIT,
		ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_READX, ST_READY, ST_EXEC,
		ST_DRAW_RD, ST_DRAW_CAP, ST_DBIT, ST_DMOD, ST_DEND,
		ST_BCD0, ST_BCD1, ST_BCD2, ST_BM_RD, ST_BM_WR,
		ST_WBF, ST_WBX, ST_DONE
	} state_t;

	// instruction classes after decode
	typedef enum logic [1:0] {CLS_SIMPLE, CLS_DRAW, CLS_BCD, CLS_BLOCK} cls_t;

	// register block move kinds
	typedef enum logic [1:0] {BM_STORE, BM_LOAD, BM_SAVEF, BM_LOADF} bm_t;

	// screen port control
	typedef struct packed {
		logic             we;
		logic             clr;
		logic [COL_W-1:0] addr;
		logic [63:0]      wdata;
	} scr_ctrl_t;

	// full opcodes
	localparam logic [15:0] OPC_CLS    = 16'h00E0;
	localparam logic [15:0] OPC_RET    = 16'h00EE;
	localparam logic [15:0] OPC_EXIT   = 16'h00FD;
	localparam logic [15:0] OPC_LOW    = 16'h00FE;
	localparam logic [15:0] OPC_HIGH   = 16'h00FF;
	localparam logic [15:0] OPC_SCR_R  = 16'h00FB;
	localparam logic [15:0] OPC_SCR_L  = 16'h00FC;
	localparam logic [15:0] OPC_SCR_D  = 16'h00C0;
	localparam logic [15:0] OPC_SCR_DM = 16'hFFF0;

	// low byte selectors
	localparam logic [7:0] KK_SKP   = 8'h9E;
	localparam logic [7:0] KK_SKNP  = 8'hA1;
	localparam logic [7:0] KK_GETDT = 8'h07;
	localparam logic [7:0] KK_WAITK = 8'h0A;
	localparam logic [7:0] KK_SETDT = 8'h15;
	localparam logic [7:0] KK_SETST = 8'h18;
	localparam logic [7:0] KK_ADDI  = 8'h1E;
	localparam logic [7:0] KK_FONT  = 8'h29;
	localparam logic [7:0] KK_BIGF  = 8'h30;
	localparam logic [7:0] KK_BCD   = 8'h33;
	localparam logic [7:0] KK_STORE = 8'h55;
	localparam logic [7:0] KK_LOAD  = 8'h65;
	localparam logic [7:0] KK_SAVEF = 8'h75;
	localparam logic [7:0] KK_LOADF = 8'h85;

	// ALU selectors of 8xyN
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// small and big hex glyphs loaded at the bottom of memory
	localparam logic [7:0] FONT [GLYPH_BYTES] = '{
		8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
		8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
		8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
		8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80,
		8'h3C,8'h7E,8'hE7,8'hC3,8'hC3,8'hC3,8'hC3,8'hE7,8'h7E,8'h3C,
		8'h18,8'h38,8'h58,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h3C,
		8'h3E,8'h7F,8'hC3,8'h06,8'h0C,8'h18,8'h30,8'h60,8'hFF,8'hFF,
		8'h3C,8'h7E,8'hC3,8'h03,8'h0E,8'h0E,8'h03,8'hC3,8'h7E,8'h3C,
		8'h06,8'h0E,8'h1E,8'h36,8'h66,8'hC6,8'hFF,8'hFF,8'h06,8'h06,
		8'hFF,8'hFF,8'hC0,8'hC0,8'hFC,8'hFE,8'h03,8'hC3,8'h7E,8'h3C,
		8'h3E,8'h7C,8'hC0,8'hC0,8'hFC,8'hFE,8'hC3,8'hC3,8'h7E,8'h3C,
		8'hFF,8'hFF,8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'h60,8'h60,
		8'h3C,8'h7E,8'hC3,8'hC3,8'h7E,8'h7E,8'hC3,8'hC3,8'h7E,8'h3C,
		8'h3C,8'h7E,8'hC3,8'hC3,8'h7F,8'h3F,8'h03,8'h03,8'h3E,8'h7C
	};

endpackage

// ----- rtl/sc8_screen.sv -----
// Screen column store: one read/write port, registered read, per-column valid bits.
module sc8_screen (
	input  logic                clk,
	input  logic                arst_n,
	input  sc8_pkg::scr_ctrl_t  ctl,
	output logic [63:0]         rdata
);

	logic [63:0] mem [sc8_pkg::SCREEN_COLUMNS];
	logic [sc8_pkg::SCREEN_COLUMNS-1:0] vld_q;
	logic [63:0] rdata_q;
	logic        rvld_q;

	// column array
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.addr] <= ctl.wdata;
		end
		rdata_q <= mem[ctl.addr];
	end

	// valid bits: a column never written since clear reads as blank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[ctl.addr];
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.we) begin
				vld_q[ctl.addr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : 64'd0;

endmodule

// ----- rtl/superchip8_instruction_core_top.sv -----
// Channel | Dir | tdata (low bit up)                                       | tuser
// s_      | in  | address 12, write_byte 8, key_index 4, key_down 1,        | operation 3
//         |     | random_byte 8, column 7                                  |
// m_      | out | read_value 8, column_bits 64, program_counter_out 12,     | -
//         |     | halted, fault, waiting_key, sound_on, high_res_out, pad 7|
// Items are taken one at a time; the next item is accepted once the result is taken.
// Load/tick/key and halted execute go straight to the result; byte and column reads
// wait for the registered read. Execute fetches both opcode bytes and reads Vx and Vy;
// Fx33 then writes three digits, block moves read and write each register, and draws
// read each sprite byte and write the screen per set pixel, all bound by the single
// memory ports. After reset a pass over every address fills memory with glyphs and zeros.
// A stalled result holds in the output register and blocks new items.
module superchip8_instruction_core_top #(
	parameter int FLAG_SLOTS    = sc8_pkg::FLAG_SLOTS,
	parameter int PROGRAM_START = sc8_pkg::PROGRAM_START
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // address, write_byte, key_index, key_down, random_byte, column
	input  logic [2:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata   // read_value, column_bits, pc, halted, fault, waiting, sound, hires
);

	`include "superchip8_instruction_core_top_macros.svh"

	localparam int FS_W  = (FLAG_SLOTS > 1) ? $clog2(FLAG_SLOTS) : 1;
	localparam int AW    = $clog2(sc8_pkg::MEM_BYTES);

	sc8_pkg::state_t state_q, state_d;

	// latched input item
	logic [2:0]    oper_q;
	logic [AW-1:0] addr_q;
	logic [7:0]    wbyte_q, rnd_q;
	logic [3:0]    kidx_q;
	logic          kdown_q;
	logic [6:0]    col_q;

	// architectural state
	logic [11:0] pc_q;
	logic [15:0] i_q;
	logic [3:0]  sp_q;
	logic [11:0] stack_q [sc8_pkg::STACK_DEPTH];
	logic [7:0]  dt_q, st_q;
	logic [7:0]  flags_q [FLAG_SLOTS];
	logic        hires_q, run_q, fault_q;
	logic [15:0] keys_q;

	// work registers
	logic [AW-1:0] clr_q;
	logic [15:0]   op_q;
	logic [7:0]    vx_q, vy_q;
	logic          wf_q, wx_q;
	logic [7:0]    wfv_q, wxv_q;
	logic          wait_q;
	logic [7:0]    rv_q;
	logic [63:0]   colbits_q;
	logic [7:0]    spr_q;
	logic [3:0]    r_q, bi_q;
	logic          h_q, p_q, hit_q;
	logic [2:0]    j_q;
	sc8_pkg::bm_t  bm_q;
	logic          out_vld_q;
	logic [95:0]   out_q;

	// memories
	logic [7:0]    mem [sc8_pkg::MEM_BYTES];
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wd, mem_rd_q;
	logic [7:0]    vmem [16];
	logic [15:0]   v_vld_q;
	logic          v_rvld_q;
	logic [7:0]    v_rdata_q, v_rd;
	logic          v_we;
	logic [3:0]    v_addr;
	logic [7:0]    v_wd;
	sc8_pkg::scr_ctrl_t scr_ctl;
	logic [63:0]   scr_rd;

	logic accept;
	assign s_tready = (state_q == sc8_pkg::ST_IDLE) && !out_vld_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// opcode fields
	logic [3:0]  op_hi, ox, on;
	logic [7:0]  kk;
	logic [11:0] nnn;
	assign op_hi = op_q[15:12];
	assign ox    = op_q[11:8];
	assign on    = op_q[3:0];
	assign kk    = op_q[7:0];
	assign nnn   = op_q[11:0];

	// lowest pressed key
	logic       key_any;
	logic [3:0] key_low;
	always_comb begin
		key_any = 1'b0;
		key_low = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k]) begin
				key_any = 1'b1;
				key_low = 4'(k);
			end
		end
	end

	// instruction decode and execute
	sc8_pkg::cls_t ex_cls;
	sc8_pkg::bm_t  ex_bm;
	logic [11:0] ex_pc, pc_adv, pc_skip;
	logic [15:0] ex_i;
	logic [3:0]  ex_sp;
	logic        ex_push, ex_wx, ex_wf, ex_hires, ex_run, ex_clr, ex_wait;
	logic [7:0]  ex_wxv, ex_wfv, ex_dt, ex_st;
	logic [8:0]  sum9;
	logic        key_hit;
	assign pc_adv  = pc_q + 12'd2;
	assign pc_skip = pc_q + 12'd4;
	assign sum9    = {1'b0, vx_q} + {1'b0, vy_q};
	assign key_hit = keys_q[vx_q[3:0]];

	always_comb begin
		ex_cls   = sc8_pkg::CLS_SIMPLE;
		ex_bm    = sc8_pkg::BM_STORE;
		ex_pc    = pc_adv;
		ex_i     = i_q;
		ex_sp    = sp_q;
		ex_push  = 1'b0;
		ex_wx    = 1'b0;
		ex_wxv   = 8'd0;
		ex_wf    = 1'b0;
		ex_wfv   = 8'd0;
		ex_dt    = dt_q;
		ex_st    = st_q;
		ex_hires = hires_q;
		ex_run   = run_q;
		ex_clr   = 1'b0;
		ex_wait  = 1'b0;
		unique case (op_hi)
			4'h0: begin
				if ((op_q & sc8_pkg::OPC_SCR_DM) == sc8_pkg::OPC_SCR_D
						|| op_q == sc8_pkg::OPC_SCR_R || op_q == sc8_pkg::OPC_SCR_L) begin
					ex_pc = pc_adv;
				end else if (op_q == sc8_pkg::OPC_CLS) begin
					ex_clr = 1'b1;
				end else if (op_q == sc8_pkg::OPC_RET) begin
					ex_pc = stack_q[sp_q] + 12'd2;
					ex_sp = sp_q - 4'd1;
				end else if (op_q == sc8_pkg::OPC_EXIT) begin
					ex_run = 1'b0;
				end else if (op_q == sc8_pkg::OPC_LOW) begin
					ex_hires = 1'b0;
				end else if (op_q == sc8_pkg::OPC_HIGH) begin
					ex_hires = 1'b1;
				end else begin
					ex_pc = nnn;
				end
			end
			4'h1: ex_pc = nnn;
			4'h2: begin
				ex_sp   = sp_q + 4'd1;
				ex_push = 1'b1;
				ex_pc   = nnn;
			end
			4'h3: if (vx_q == kk) ex_pc = pc_skip;
			4'h4: if (vx_q != kk) ex_pc = pc_skip;
			4'h5: if (vx_q == vy_q) ex_pc = pc_skip;
			4'h6: begin
				ex_wx  = 1'b1;
				ex_wxv = kk;
			end
			4'h7: begin
				ex_wx  = 1'b1;
				ex_wxv = vx_q + kk;
			end
			4'h8: begin
				unique case (on)
					sc8_pkg::ALU_MOV: begin ex_wx = 1'b1; ex_wxv = vy_q; end
					sc8_pkg::ALU_OR:  begin ex_wx = 1'b1; ex_wxv = vx_q | vy_q; end
					sc8_pkg::ALU_AND: begin ex_wx = 1'b1; ex_wxv = vx_q & vy_q; end
					sc8_pkg::ALU_XOR: begin ex_wx = 1'b1; ex_wxv = vx_q ^ vy_q; end
					sc8_pkg::ALU_ADD: begin
						ex_wf = 1'b1; ex_wfv = {7'd0, sum9[8]};
						ex_wx = 1'b1; ex_wxv = sum9[7:0];
					end
					sc8_pkg::ALU_SUB: begin
						ex_wf = 1'b1; ex_wfv = {7'd0, vx_q > vy_q};
						ex_wx = 1'b1; ex_wxv = vx_q - vy_q;
					end
					sc8_pkg::ALU_SHR: begin
						ex_wf = 1'b1; ex_wfv = {7'd0, vx_q[0]};
						ex_wx = 1'b1; ex_wxv = {1'b0, vx_q[7:1]};
					end
					sc8_pkg::ALU_RSB: begin
						ex_wf = 1'b1; ex_wfv = {7'd0, vy_q > vx_q};
						ex_wx = 1'b1; ex_wxv = vy_q - vx_q;
					end
					sc8_pkg::ALU_SHL: begin
						ex_wf = 1'b1; ex_wfv = {7'd0, vx_q[7]};
						ex_wx = 1'b1; ex_wxv = {vx_q[6:0], 1'b0};
					end
					default: ex_wx = 1'b0;
				endcase
			end
			4'h9: if (vx_q != vy_q) ex_pc = pc_skip;
			4'hA: ex_i = {4'd0, nnn};
			// V0 arrives from the register file in this cycle
			4'hB: ex_pc = nnn + {4'd0, v_rd};
			4'hC: begin
				ex_wx  = 1'b1;
				ex_wxv = rnd_q & kk;
			end
			4'hD: ex_cls = sc8_pkg::CLS_DRAW;
			4'hE: begin
				if (kk == sc8_pkg::KK_SKP && key_hit) begin
					ex_pc = pc_skip;
				end else if (kk == sc8_pkg::KK_SKNP && !key_hit) begin
					ex_pc = pc_skip;
				end
			end
			4'hF: begin
				unique case (kk)
					sc8_pkg::KK_GETDT: begin ex_wx = 1'b1; ex_wxv = dt_q; end
					sc8_pkg::KK_WAITK: begin
						if (key_any) begin
							ex_wx  = 1'b1;
							ex_wxv = {4'd0, key_low};
						end else begin
							ex_pc   = pc_q;
							ex_wait = 1'b1;
						end
					end
					sc8_pkg::KK_SETDT: ex_dt = vx_q;
					sc8_pkg::KK_SETST: ex_st = vx_q;
					sc8_pkg::KK_ADDI:  ex_i = i_q + {8'd0, vx_q};
					sc8_pkg::KK_FONT:  ex_i = {6'd0, vx_q, 2'b00} + {8'd0, vx_q};
					sc8_pkg::KK_BIGF:
						ex_i = {4'd0, ({1'b0, vx_q, 3'b000} + {3'b000, vx_q, 1'b0}) + 12'd80};
					sc8_pkg::KK_BCD:   ex_cls = sc8_pkg::CLS_BCD;
					sc8_pkg::KK_STORE: begin ex_cls = sc8_pkg::CLS_BLOCK; ex_bm = sc8_pkg::BM_STORE; end
					sc8_pkg::KK_LOAD:  begin ex_cls = sc8_pkg::CLS_BLOCK; ex_bm = sc8_pkg::BM_LOAD; end
					sc8_pkg::KK_SAVEF: begin ex_cls = sc8_pkg::CLS_BLOCK; ex_bm = sc8_pkg::BM_SAVEF; end
					sc8_pkg::KK_LOADF: begin ex_cls = sc8_pkg::CLS_BLOCK; ex_bm = sc8_pkg::BM_LOADF; end
					default: ex_wx = 1'b0;
				endcase
			end
			default: ex_wx = 1'b0;
		endcase
	end

	// decimal digits for Fx33
	logic [1:0]  bcd_h;
	logic [6:0]  bcd_rem;
	logic [14:0] bcd_prod;
	logic [3:0]  bcd_t, bcd_o;
	always_comb begin
		if (vx_q >= 8'd200) begin
			bcd_h   = 2'd2;
			bcd_rem = 7'(vx_q - 8'd200);
		end else if (vx_q >= 8'd100) begin
			bcd_h   = 2'd1;
			bcd_rem = 7'(vx_q - 8'd100);
		end else begin
			bcd_h   = 2'd0;
			bcd_rem = vx_q[6:0];
		end
		// divide by ten via reciprocal, exact for the 7-bit remainder
		bcd_prod = {8'd0, bcd_rem} * 15'd205;
		bcd_t    = bcd_prod[14:11];
		bcd_o    = 4'(bcd_rem - {bcd_t, 3'b000} - {2'b00, bcd_t, 1'b0});
	end

	// sprite geometry for the current bit
	logic [7:0]       xs, ys;
	logic [6:0]       dcol;
	logic [5:0]       ry_lo;
	logic [63:0]      dmask, hmask;
	logic             dbit, dlast;
	logic [4:0]       spr_off;
	always_comb begin
		xs      = vx_q + {4'd0, h_q, 3'd0} + {5'd0, j_q};
		ys      = vy_q + {4'd0, r_q};
		ry_lo   = {ys[4:0], 1'b0};
		if (hires_q) begin
			dcol  = xs[6:0];
			dmask = 64'd1 << ys[5:0];
			hmask = dmask;
		end else begin
			dcol  = {xs[5:0], p_q};
			dmask = 64'd3 << ry_lo;
			hmask = p_q ? 64'd0 : (64'd1 << ry_lo);
		end
		dbit    = spr_q[3'd7 - j_q];
		spr_off = (on == 4'd0) ? {r_q, h_q} : {1'b0, r_q};
		dlast   = (on == 4'd0) ? (r_q == 4'd15 && h_q) : (r_q == on - 4'd1);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sc8_pkg::ST_CLEAR:  if (clr_q == AW'(sc8_pkg::MEM_BYTES - 1)) state_d = sc8_pkg::ST_IDLE;
			sc8_pkg::ST_IDLE:   if (accept) state_d = sc8_pkg::ST_OPER;
			sc8_pkg::ST_OPER: begin
				priority case (oper_q)
					sc8_pkg::OPER_READ, sc8_pkg::OPER_COLUMN: state_d = sc8_pkg::ST_RDWAIT;
					sc8_pkg::OPER_EXEC: begin
						if (!run_q || fault_q || pc_q == 12'hFFF) state_d = sc8_pkg::ST_DONE;
						else state_d = sc8_pkg::ST_FETCH0;
					end
					default: state_d = sc8_pkg::ST_DONE;
				endcase
			end
			sc8_pkg::ST_RDWAIT: state_d = sc8_pkg::ST_DONE;
			sc8_pkg::ST_FETCH0: state_d = sc8_pkg::ST_FETCH1;
			sc8_pkg::ST_FETCH1: state_d = sc8_pkg::ST_FETCH2;
			sc8_pkg::ST_FETCH2: state_d = sc8_pkg::ST_READX;
			sc8_pkg::ST_READX:  state_d = sc8_pkg::ST_READY;
			sc8_pkg::ST_READY:  state_d = sc8_pkg::ST_EXEC;
			sc8_pkg::ST_EXEC: begin
				unique case (ex_cls)
					sc8_pkg::CLS_DRAW:  state_d = sc8_pkg::ST_DRAW_RD;
					sc8_pkg::CLS_BCD:   state_d = sc8_pkg::ST_BCD0;
					sc8_pkg::CLS_BLOCK: state_d = sc8_pkg::ST_BM_RD;
					default:            state_d = sc8_pkg::ST_WBF;
				endcase
			end
			sc8_pkg::ST_DRAW_RD:  state_d = sc8_pkg::ST_DRAW_CAP;
			sc8_pkg::ST_DRAW_CAP: state_d = sc8_pkg::ST_DBIT;
			sc8_pkg::ST_DBIT: begin
				if (dbit) state_d = sc8_pkg::ST_DMOD;
				else if (j_q == 3'd7) state_d = dlast ? sc8_pkg::ST_DEND : sc8_pkg::ST_DRAW_RD;
			end
			sc8_pkg::ST_DMOD: begin
				if (!hires_q && !p_q) state_d = sc8_pkg::ST_DBIT;
				else if (j_q == 3'd7) state_d = dlast ? sc8_pkg::ST_DEND : sc8_pkg::ST_DRAW_RD;
				else state_d = sc8_pkg::ST_DBIT;
			end
			sc8_pkg::ST_DEND: state_d = sc8_pkg::ST_WBF;
			sc8_pkg::ST_BCD0: state_d = sc8_pkg::ST_BCD1;
			sc8_pkg::ST_BCD1: state_d = sc8_pkg::ST_BCD2;
			sc8_pkg::ST_BCD2: state_d = sc8_pkg::ST_WBF;
			sc8_pkg::ST_BM_RD: state_d = sc8_pkg::ST_BM_WR;
			sc8_pkg::ST_BM_WR: state_d = (bi_q == ox) ? sc8_pkg::ST_WBF : sc8_pkg::ST_BM_RD;
			sc8_pkg::ST_WBF:  state_d = sc8_pkg::ST_WBX;
			sc8_pkg::ST_WBX:  state_d = sc8_pkg::ST_DONE;
			sc8_pkg::ST_DONE: state_d = sc8_pkg::ST_IDLE;
			default: state_d = sc8_pkg::ST_IDLE;
		endcase
	end

	// memory port controls per state
	logic flag_ok;
	assign flag_ok = {1'b0, bi_q} < 5'(FLAG_SLOTS);
	always_comb begin
		mem_we        = 1'b0;
		mem_addr      = pc_q;
		mem_wd        = 8'd0;
		v_we          = 1'b0;
		v_addr        = 4'd0;
		v_wd          = 8'd0;
		scr_ctl.we    = 1'b0;
		scr_ctl.clr   = 1'b0;
		scr_ctl.addr  = dcol;
		scr_ctl.wdata = scr_rd ^ dmask;
		unique case (state_q)
			sc8_pkg::ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				mem_wd   = (clr_q < AW'(sc8_pkg::GLYPH_BYTES)) ? sc8_pkg::FONT[clr_q[7:0]] : 8'd0;
			end
			sc8_pkg::ST_OPER: begin
				mem_addr     = addr_q;
				mem_we       = (oper_q == sc8_pkg::OPER_LOAD);
				mem_wd       = wbyte_q;
				scr_ctl.addr = col_q;
			end
			sc8_pkg::ST_FETCH0: mem_addr = pc_q;
			sc8_pkg::ST_FETCH1: mem_addr = pc_adv - 12'd1;
			sc8_pkg::ST_FETCH2: v_addr = op_q[11:8];
			sc8_pkg::ST_READX:  v_addr = op_q[7:4];
			sc8_pkg::ST_READY:  v_addr = 4'd0;
			sc8_pkg::ST_EXEC:   scr_ctl.clr = ex_clr;
			sc8_pkg::ST_DRAW_RD: mem_addr = i_q[11:0] + {7'd0, spr_off};
			sc8_pkg::ST_DMOD:   scr_ctl.we = 1'b1;
			sc8_pkg::ST_BCD0: begin
				mem_we = 1'b1; mem_addr = i_q[11:0]; mem_wd = {6'd0, bcd_h};
			end
			sc8_pkg::ST_BCD1: begin
				mem_we = 1'b1; mem_addr = i_q[11:0] + 12'd1; mem_wd = {4'd0, bcd_t};
			end
			sc8_pkg::ST_BCD2: begin
				mem_we = 1'b1; mem_addr = i_q[11:0] + 12'd2; mem_wd = {4'd0, bcd_o};
			end
			sc8_pkg::ST_BM_RD: begin
				mem_addr = i_q[11:0] + {8'd0, bi_q};
				v_addr   = bi_q;
			end
			sc8_pkg::ST_BM_WR: begin
				mem_addr = i_q[11:0] + {8'd0, bi_q};
				v_addr   = bi_q;
				unique case (bm_q)
					sc8_pkg::BM_STORE: begin mem_we = 1'b1; mem_wd = v_rd; end
					sc8_pkg::BM_LOAD:  begin v_we = 1'b1; v_wd = mem_rd_q; end
					sc8_pkg::BM_LOADF: begin v_we = flag_ok; v_wd = flags_q[bi_q[FS_W-1:0]]; end
					default: v_we = 1'b0;
				endcase
			end
			sc8_pkg::ST_WBF: begin v_we = wf_q; v_addr = 4'hF; v_wd = wfv_q; end
			sc8_pkg::ST_WBX: begin v_we = wx_q; v_addr = ox; v_wd = wxv_q; end
			default: mem_we = 1'b0;
		endcase
	end

	// main memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		mem_rd_q <= mem[mem_addr];
	end

	// register file V0..VF
	always_ff @(posedge clk) begin
		if (v_we) begin
			vmem[v_addr] <= v_wd;
		end
		v_rdata_q <= vmem[v_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_vld_q  <= '0;
			v_rvld_q <= 1'b0;
		end else begin
			v_rvld_q <= v_vld_q[v_addr];
			if (v_we) v_vld_q[v_addr] <= 1'b1;
		end
	end
	assign v_rd = v_rvld_q ? v_rdata_q : 8'd0;

	sc8_screen u_screen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scr_ctl),
		.rdata  (scr_rd)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sc8_pkg::ST_CLEAR;
		else state_q <= state_d;
	end

	// datapath and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			pc_q      <= 12'(PROGRAM_START);
			i_q       <= '0;
			sp_q      <= '0;
			stack_q   <= '{default: '0};
			flags_q   <= '{default: '0};
			dt_q      <= '0;
			st_q      <= '0;
			hires_q   <= 1'b0;
			run_q     <= 1'b1;
			fault_q   <= 1'b0;
			keys_q    <= '0;
			wf_q      <= 1'b0;
			wx_q      <= 1'b0;
			wait_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready) out_vld_q <= 1'b0;
			unique case (state_q)
				sc8_pkg::ST_CLEAR: clr_q <= clr_q + AW'(1);
				sc8_pkg::ST_IDLE: begin
					if (accept) begin
						oper_q    <= s_tuser;
						addr_q    <= s_tdata[11:0];
						wbyte_q   <= s_tdata[19:12];
						kidx_q    <= s_tdata[23:20];
						kdown_q   <= s_tdata[24];
						rnd_q     <= s_tdata[32:25];
						col_q     <= s_tdata[39:33];
						rv_q      <= '0;
						colbits_q <= '0;
						wait_q    <= 1'b0;
						wf_q      <= 1'b0;
						wx_q      <= 1'b0;
					end
				end
				sc8_pkg::ST_OPER: begin
					priority case (oper_q)
						sc8_pkg::OPER_TICK: begin
							if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
							if (st_q != 8'd0) st_q <= st_q - 8'd1;
						end
						sc8_pkg::OPER_KEY: keys_q[kidx_q] <= kdown_q;
						sc8_pkg::OPER_EXEC:
							if (run_q && !fault_q && pc_q == 12'hFFF) fault_q <= 1'b1;
						default: fault_q <= fault_q;
					endcase
				end
				sc8_pkg::ST_RDWAIT: begin
					if (oper_q == sc8_pkg::OPER_READ) rv_q <= mem_rd_q;
					else colbits_q <= scr_rd;
				end
				sc8_pkg::ST_FETCH1: op_q[15:8] <= mem_rd_q;
				sc8_pkg::ST_FETCH2: op_q[7:0]  <= mem_rd_q;
				sc8_pkg::ST_READX:  vx_q <= v_rd;
				sc8_pkg::ST_READY:  vy_q <= v_rd;
				sc8_pkg::ST_EXEC: begin
					pc_q    <= ex_pc;
					i_q     <= ex_i;
					sp_q    <= ex_sp;
					if (ex_push) stack_q[ex_sp] <= pc_q;
					dt_q    <= ex_dt;
					st_q    <= ex_st;
					hires_q <= ex_hires;
					run_q   <= ex_run;
					wait_q  <= ex_wait;
					wf_q    <= ex_wf;
					wfv_q   <= ex_wfv;
					wx_q    <= ex_wx;
					wxv_q   <= ex_wxv;
					bm_q    <= ex_bm;
					bi_q    <= '0;
					r_q     <= '0;
					h_q     <= 1'b0;
					j_q     <= '0;
					p_q     <= 1'b0;
					hit_q   <= 1'b0;
				end
				sc8_pkg::ST_DRAW_CAP: spr_q <= mem_rd_q;
				sc8_pkg::ST_DBIT: begin
					if (!dbit) begin
						j_q <= j_q + 3'd1;
						if (j_q == 3'd7) begin
							if (on == 4'd0) begin
								h_q <= ~h_q;
								if (h_q) r_q <= r_q + 4'd1;
							end else begin
								r_q <= r_q + 4'd1;
							end
						end
					end
				end
				sc8_pkg::ST_DMOD: begin
					hit_q <= hit_q | (|(scr_rd & hmask));
					if (!hires_q && !p_q) begin
						p_q <= 1'b1;
					end else begin
						p_q <= 1'b0;
						j_q <= j_q + 3'd1;
						if (j_q == 3'd7) begin
							if (on == 4'd0) begin
								h_q <= ~h_q;
								if (h_q) r_q <= r_q + 4'd1;
							end else begin
								r_q <= r_q + 4'd1;
							end
						end
					end
				end
				sc8_pkg::ST_DEND: begin
					wf_q  <= 1'b1;
					wfv_q <= {7'd0, hit_q};
				end
				sc8_pkg::ST_BM_WR: begin
					if (bm_q == sc8_pkg::BM_SAVEF && flag_ok) flags_q[bi_q[FS_W-1:0]] <= v_rd;
					bi_q <= bi_q + 4'd1;
				end
				sc8_pkg::ST_DONE: begin
					out_vld_q <= 1'b1;
					out_q     <= {7'd0, hires_q, st_q != 8'd0, wait_q, fault_q, !run_q,
						pc_q, colbits_q, rv_q};
				end
				default: wf_q <= wf_q;
			endcase
		end
	end

	// checks
	`SC8_ASSERT_NOW(a_no_take_in_clear, state_q == sc8_pkg::ST_CLEAR, !s_tready, "item taken during memory fill")
	`SC8_ASSERT_NOW(a_take_only_empty, s_tvalid && s_tready, !m_tvalid, "item taken while result pending")
	`SC8_ASSERT_NOW(a_scr_write_draw, scr_ctl.we, state_q == sc8_pkg::ST_DMOD, "screen write outside draw")
	`SC8_ASSERT_NEXT(a_done_shows, state_q == sc8_pkg::ST_DONE, m_tvalid, "finished item not presented")

endmodule

// ----- tb/superchip8_instruction_core_checker.sv -----
module superchip8_instruction_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // address, write_byte, key_index, key_down, random_byte, column
	input  logic [2:0]  s_tuser,   // operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,   // read_value, column_bits, pc, halted, fault, waiting, sound, hires
	output int          errors
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow machine state
	logic [7:0]  mem [sc8_pkg::MEM_BYTES];
	logic [63:0] scr [sc8_pkg::SCREEN_COLUMNS];
	logic [7:0]  vreg [16];
	logic [15:0] idx;
	logic [11:0] pc;
	logic [11:0] rstack [sc8_pkg::STACK_DEPTH];
	logic [3:0]  sp;
	logic [7:0]  dly;
	logic [7:0]  snd;
	logic [7:0]  flags [sc8_pkg::FLAG_SLOTS];
	logic        hires;
	logic        run;
	logic        faulted;
	logic [15:0] keys;

	logic [95:0] result_q [$];
	int          mism;
	int          outstanding;
	int          result_no;

	initial begin
		for (int a = 0; a < sc8_pkg::MEM_BYTES; a++)
			mem[a] = (a < sc8_pkg::GLYPH_BYTES) ? sc8_pkg::FONT[a] : 8'h00;
		for (int c = 0; c < sc8_pkg::SCREEN_COLUMNS; c++) scr[c] = '0;
		for (int r = 0; r < 16; r++) begin
			vreg[r] = '0;
			rstack[r] = '0;
		end
		for (int f = 0; f < sc8_pkg::FLAG_SLOTS; f++) flags[f] = '0;
		idx = '0;
		pc = 12'(sc8_pkg::PROGRAM_START);
		sp = '0;
		dly = '0;
		snd = '0;
		hires = 1'b0;
		run = 1'b1;
		faulted = 1'b0;
		keys = '0;
		mism = 0;
		outstanding = 0;
		result_no = 0;
		errors = 0;
	end

	function automatic logic [7:0] mem_at(int off);
		return mem[12'(idx + 16'(off))];
	endfunction

	// XOR one pixel (2x2 block in low-res); returns the prior state
	function automatic logic flip(int x, int y);
		int cx, ry;
		logic hit;
		if (hires) begin
			cx = x & 127;
			ry = y & 63;
			hit = scr[cx][ry];
			scr[cx][ry] = ~scr[cx][ry];
		end else begin
			cx = (x & 63) * 2;
			ry = (y & 31) * 2;
			hit = scr[cx][ry];
			scr[cx][ry +: 2] = scr[cx][ry +: 2] ^ 2'b11;
			scr[cx + 1][ry +: 2] = scr[cx + 1][ry +: 2] ^ 2'b11;
		end
		return hit;
	endfunction

	function automatic logic draw_row(logic [7:0] bits, int x, int y);
		logic hit;
		hit = 1'b0;
		for (int j = 0; j < 8; j++)
			if (bits[7 - j]) hit |= flip(x + j, y);
		return hit;
	endfunction

	// one instruction; waiting is set when a key wait found nothing pressed
	task automatic run_instr(input logic [7:0] rnd, output logic waiting);
		logic [15:0] op;
		logic [3:0]  hi, x, y, n;
		logic [7:0]  kk, vx, vy;
		logic [11:0] nnn, a;
		logic [8:0]  sum;
		logic        adv, hit;
		adv = 1'b1;
		waiting = 1'b0;
		if (!run || faulted) return;
		if (pc == 12'hFFF) begin
			faulted = 1'b1;
			return;
		end
		op = {mem[pc], mem[pc + 12'd1]};
		hi = op[15:12];
		x = op[11:8];
		y = op[7:4];
		n = op[3:0];
		kk = op[7:0];
		nnn = op[11:0];
		vx = vreg[x];
		vy = vreg[y];
		case (hi)
			4'h0: begin
				if ((op & sc8_pkg::OPC_SCR_DM) == sc8_pkg::OPC_SCR_D
						|| op == sc8_pkg::OPC_SCR_R || op == sc8_pkg::OPC_SCR_L) begin
				end else if (op == sc8_pkg::OPC_CLS) begin
					for (int c = 0; c < sc8_pkg::SCREEN_COLUMNS; c++) scr[c] = '0;
				end else if (op == sc8_pkg::OPC_RET) begin
					pc = rstack[sp];
					sp = sp - 4'd1;
				end else if (op == sc8_pkg::OPC_EXIT) begin
					run = 1'b0;
				end else if (op == sc8_pkg::OPC_LOW) begin
					hires = 1'b0;
				end else if (op == sc8_pkg::OPC_HIGH) begin
					hires = 1'b1;
				end else begin
					pc = nnn;
					adv = 1'b0;
				end
			end
			4'h1: begin
				pc = nnn;
				adv = 1'b0;
			end
			4'h2: begin
				sp = sp + 4'd1;
				rstack[sp] = pc;
				pc = nnn;
				adv = 1'b0;
			end
			4'h3: if (vx == kk) pc = pc + 12'd2;
			4'h4: if (vx != kk) pc = pc + 12'd2;
			4'h5: if (vx == vy) pc = pc + 12'd2;
			4'h6: vreg[x] = kk;
			4'h7: vreg[x] = vx + kk;
			4'h8: begin
				case (n)
					sc8_pkg::ALU_MOV: vreg[x] = vy;
					sc8_pkg::ALU_OR:  vreg[x] = vx | vy;
					sc8_pkg::ALU_AND: vreg[x] = vx & vy;
					sc8_pkg::ALU_XOR: vreg[x] = vx ^ vy;
					sc8_pkg::ALU_ADD: begin
						sum = {1'b0, vx} + {1'b0, vy};
						vreg[15] = {7'd0, sum[8]};
						vreg[x] = sum[7:0];
					end
					sc8_pkg::ALU_SUB: begin
						vreg[15] = {7'd0, vx > vy};
						vreg[x] = vx - vy;
					end
					sc8_pkg::ALU_SHR: begin
						vreg[15] = {7'd0, vx[0]};
						vreg[x] = vx >> 1;
					end
					sc8_pkg::ALU_RSB: begin
						vreg[15] = {7'd0, vy > vx};
						vreg[x] = vy - vx;
					end
					sc8_pkg::ALU_SHL: begin
						vreg[15] = {7'd0, vx[7]};
						vreg[x] = vx << 1;
					end
					default: ;
				endcase
			end
			4'h9: if (vx != vy) pc = pc + 12'd2;
			4'hA: idx = {4'd0, nnn};
			4'hB: begin
				pc = nnn + {4'd0, vreg[0]};
				adv = 1'b0;
			end
			4'hC: vreg[x] = rnd & kk;
			4'hD: begin
				hit = 1'b0;
				if (n == 4'd0) begin
					for (int i = 0; i < 16; i++) begin
						hit |= draw_row(mem_at(i * 2), int'(vx), int'(vy) + i);
						hit |= draw_row(mem_at(i * 2 + 1), int'(vx) + 8, int'(vy) + i);
					end
				end else begin
					for (int i = 0; i < int'(n); i++)
						hit |= draw_row(mem_at(i), int'(vx), int'(vy) + i);
				end
				vreg[15] = {7'd0, hit};
			end
			4'hE: begin
				if (kk == sc8_pkg::KK_SKP && keys[vx[3:0]]) pc = pc + 12'd2;
				else if (kk == sc8_pkg::KK_SKNP && !keys[vx[3:0]]) pc = pc + 12'd2;
			end
			default: begin
				a = idx[11:0];
				case (kk)
					sc8_pkg::KK_GETDT: vreg[x] = dly;
					sc8_pkg::KK_WAITK: begin
						adv = 1'b0;
						waiting = 1'b1;
						for (int i = 0; i < 16; i++)
							if (waiting && keys[i]) begin
								vreg[x] = 8'(i);
								adv = 1'b1;
								waiting = 1'b0;
							end
					end
					sc8_pkg::KK_SETDT: dly = vx;
					sc8_pkg::KK_SETST: snd = vx;
					sc8_pkg::KK_ADDI:  idx = idx + {8'd0, vx};
					sc8_pkg::KK_FONT:  idx = 16'(5 * int'(vx));
					sc8_pkg::KK_BIGF:  idx = 16'(10 * int'(vx) + 80);
					sc8_pkg::KK_BCD: begin
						mem[a] = vx / 8'd100;
						mem[a + 12'd1] = (vx / 8'd10) % 8'd10;
						mem[a + 12'd2] = vx % 8'd10;
					end
					sc8_pkg::KK_STORE:
						for (int i = 0; i <= int'(x); i++) mem[12'(idx + 16'(i))] = vreg[i];
					sc8_pkg::KK_LOAD:
						for (int i = 0; i <= int'(x); i++) vreg[i] = mem_at(i);
					sc8_pkg::KK_SAVEF:
						for (int i = 0; i <= int'(x); i++)
							if (i < sc8_pkg::FLAG_SLOTS) flags[i] = vreg[i];
					sc8_pkg::KK_LOADF:
						for (int i = 0; i <= int'(x); i++)
							if (i < sc8_pkg::FLAG_SLOTS) vreg[i] = flags[i];
					default: ;
				endcase
			end
		endcase
		if (adv) pc = pc + 12'd2;
	endtask

	// expected result of one accepted item
	task automatic predict_item(input logic [2:0] op, input logic [39:0] d,
			output logic [95:0] res);
		logic [7:0]  rd;
		logic [63:0] colv;
		logic        wt;
		rd = '0;
		colv = '0;
		wt = 1'b0;
		case (op)
			sc8_pkg::OPER_LOAD:   mem[d[11:0]] = d[19:12];
			sc8_pkg::OPER_READ:   rd = mem[d[11:0]];
			sc8_pkg::OPER_EXEC:   run_instr(d[32:25], wt);
			sc8_pkg::OPER_TICK: begin
				if (dly != 0) dly = dly - 8'd1;
				if (snd != 0) snd = snd - 8'd1;
			end
			sc8_pkg::OPER_KEY:    keys[d[23:20]] = d[24];
			sc8_pkg::OPER_COLUMN: colv = scr[d[39:33]];
			default: ;
		endcase
		res = {7'd0, hires, snd != 0, wt, faulted, ~run, pc, colv, rd};
	endtask

	always @(posedge clk) begin
		logic [95:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				result_no++;
				if (result_q.size() == 0) begin
					mism++;
					if (mism <= 10) $display("result %0d arrived with none expected: %h",
						result_no, m_tdata);
				end else begin
					want = result_q.pop_front();
					outstanding--;
					if (m_tdata[88:0] !== want[88:0]) begin
						mism++;
						if (mism <= 10)
							$display({"result %0d: read %h/%h column %h/%h pc %h/%h ",
								"halt,fault,wait,sound,hires %b/%b (exp/got)"}, result_no,
								want[7:0], m_tdata[7:0], want[71:8], m_tdata[71:8],
								want[83:72], m_tdata[83:72], want[88:84], m_tdata[88:84]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_item(s_tuser, s_tdata, want);
				result_q.push_back(want);
				outstanding++;
			end
			errors <= mism + outstanding;
		end
	end
endmodule

// ----- tb/superchip8_instruction_core_top_tb.sv -----
module superchip8_instruction_core_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// codes the block does not define
	localparam logic [2:0] OPER_SPARE_A = 3'd6;
	localparam logic [2:0] OPER_SPARE_B = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // address, write_byte, key_index, key_down, random_byte, column
	logic [2:0]  s_tuser;   // operation
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // read_value, column_bits, pc, halted, fault, waiting, sound, hires
	int          errors;

	int          sent_cnt;
	int          recv_cnt;
	logic [11:0] last_pc;
	int          burst_left;
	int          gap_len;

	superchip8_instruction_core_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	superchip8_instruction_core_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// track results and the latest program counter seen
	initial begin
		recv_cnt = 0;
		last_pc = 12'(sc8_pkg::PROGRAM_START);
	end
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			recv_cnt <= recv_cnt + 1;
			last_pc <= m_tdata[83:72];
		end
	end

	// result side: changing stall modes plus one long hold-off
	initial begin
		int mode, mode_left, hold_left;
		logic held;
		m_tready = 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else if (!held && recv_cnt >= 700) begin
				held = 1'b1;
				hold_left = 400;
				m_tready = 1'b0;
			end else begin
				case (mode)
					0: m_tready = 1'b1;
					1: m_tready = ($urandom_range(0, 1) == 0);
					2: m_tready = ($urandom_range(0, 7) != 0);
					default: m_tready = (mode_left % 5) < 2;
				endcase
			end
		end
	end

	function automatic logic [39:0] rand_fields();
		return {$urandom(), $urandom()};
	endfunction

	// offer one item in bursts; drop valid only when a gap follows
	task automatic push_item(input logic [2:0] op, input logic [39:0] d);
		s_tuser = op;
		s_tdata = d;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sent_cnt++;
		@(negedge clk);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap_len > 0) begin
				s_tvalid = 1'b0;
				repeat (gap_len) @(negedge clk);
			end
		end
	endtask

	task automatic load_byte(input logic [11:0] addr, input logic [7:0] b);
		logic [39:0] d;
		d = rand_fields();
		d[11:0] = addr;
		d[19:12] = b;
		push_item(sc8_pkg::OPER_LOAD, d);
	endtask

	task automatic load_word(input logic [11:0] addr, input logic [15:0] w);
		load_byte(addr, w[15:8]);
		load_byte(addr + 12'd1, w[7:0]);
	endtask

	task automatic set_key(input logic [3:0] k, input logic down);
		logic [39:0] d;
		d = rand_fields();
		d[23:20] = k;
		d[24] = down;
		push_item(sc8_pkg::OPER_KEY, d);
	endtask

	task automatic read_column(input logic [6:0] c);
		logic [39:0] d;
		d = rand_fields();
		d[39:33] = c;
		push_item(sc8_pkg::OPER_COLUMN, d);
	endtask

	// stop offering, then wait for every result
	task automatic drain();
		s_tvalid = 1'b0;
		while (recv_cnt != sent_cnt) @(negedge clk);
	endtask

	// jump and call targets stay inside the program area
	function automatic logic [11:0] code_target();
		return 12'(sc8_pkg::PROGRAM_START) + 12'(2 * $urandom_range(0, 255));
	endfunction

	// a well formed instruction with random operands
	function automatic logic [15:0] random_instr();
		logic [3:0]  x, y;
		logic [7:0]  kk;
		logic [15:0] w;
		x = 4'($urandom());
		y = 4'($urandom());
		kk = 8'($urandom());
		case ($urandom_range(0, 19))
			0: case ($urandom_range(0, 8))
				0: w = ($urandom_range(0, 3) == 0) ? sc8_pkg::OPC_CLS : sc8_pkg::OPC_SCR_R;
				1: w = sc8_pkg::OPC_RET;
				2: w = sc8_pkg::OPC_LOW;
				3: w = sc8_pkg::OPC_HIGH;
				4: w = sc8_pkg::OPC_SCR_L;
				5: w = sc8_pkg::OPC_SCR_D | 16'($urandom_range(0, 15));
				6: w = {4'h0, code_target()};
				default: w = {4'h0, 12'($urandom())};
			endcase
			1: w = {4'h1, code_target()};
			2: w = {4'h2, code_target()};
			3: w = {4'h3, x, kk};
			4: w = {4'h4, x, kk};
			5: w = {4'h5, x, y, 4'($urandom())};
			6, 7: w = {4'h6, x, kk};
			8: w = {4'h7, x, kk};
			9, 10: w = {4'h8, x, y, 4'($urandom())};
			11: w = {4'h9, x, y, 4'h0};
			12: w = {4'hA, 12'($urandom())};
			13: w = {4'hB, 12'(sc8_pkg::PROGRAM_START) + 12'(2 * $urandom_range(0, 127))};
			14: w = {4'hC, x, kk};
			15: w = {4'hD, x, y, ($urandom_range(0, 5) == 0) ? 4'h0 : 4'($urandom())};
			16: case ($urandom_range(0, 2))
				0: w = {4'hE, x, sc8_pkg::KK_SKP};
				1: w = {4'hE, x, sc8_pkg::KK_SKNP};
				default: w = {4'hE, x, kk};
			endcase
			default: case ($urandom_range(0, 12))
				0:  w = {4'hF, x, sc8_pkg::KK_GETDT};
				1:  w = {4'hF, x, sc8_pkg::KK_WAITK};
				2:  w = {4'hF, x, sc8_pkg::KK_SETDT};
				3:  w = {4'hF, x, sc8_pkg::KK_SETST};
				4:  w = {4'hF, x, sc8_pkg::KK_ADDI};
				5:  w = {4'hF, x, sc8_pkg::KK_FONT};
				6:  w = {4'hF, x, sc8_pkg::KK_BIGF};
				7:  w = {4'hF, x, sc8_pkg::KK_BCD};
				8:  w = {4'hF, x, sc8_pkg::KK_STORE};
				9:  w = {4'hF, x, sc8_pkg::KK_LOAD};
				10: w = {4'hF, x, sc8_pkg::KK_SAVEF};
				11: w = {4'hF, x, sc8_pkg::KK_LOADF};
				default: w = {4'hF, x, kk};
			endcase
		endcase
		return w;
	endfunction

	// stimulus
	initial begin
		logic [39:0] d;
		int sel;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		sent_cnt = 0;
		burst_left = 0;
		gap_len = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: memory ends, keys, timers, spare codes, wrapped sprites
		d = rand_fields();
		d[11:0] = 12'h000;
		push_item(sc8_pkg::OPER_READ, d);
		load_byte(12'hFFF, 8'hA5);
		d[11:0] = 12'hFFF;
		push_item(sc8_pkg::OPER_READ, d);
		set_key(4'hF, 1'b1);
		push_item(sc8_pkg::OPER_TICK, rand_fields());
		push_item(OPER_SPARE_A, rand_fields());
		push_item(OPER_SPARE_B, rand_fields());
		load_word(12'h200, sc8_pkg::OPC_HIGH);
		load_word(12'h202, 16'h6A7C);
		load_word(12'h204, 16'h6B3E);
		load_word(12'h206, 16'hDAB0);
		load_word(12'h208, 16'hDAB0);
		load_word(12'h20A, sc8_pkg::OPC_LOW);
		load_word(12'h20C, 16'hDAB5);
		repeat (7) push_item(sc8_pkg::OPER_EXEC, rand_fields());
		read_column(7'd127);
		read_column(7'd0);

		// program area of random instructions, with escapes back into it
		for (int a = 0; a < 512; a += 2)
			load_word(12'(sc8_pkg::PROGRAM_START + a), random_instr());
		load_word(12'h000, {4'h1, 12'(sc8_pkg::PROGRAM_START)});
		load_word(12'h400, {4'h1, 12'(sc8_pkg::PROGRAM_START)});
		load_word(12'h402, {4'h1, 12'(sc8_pkg::PROGRAM_START)});

		// mostly execution, with patches, keys, ticks and reads mixed in
		for (int k = 0; k < 560; k++) begin
			sel = $urandom_range(0, 99);
			d = rand_fields();
			if (sel < 55) push_item(sc8_pkg::OPER_EXEC, d);
			else if (sel < 62) load_word(code_target(), random_instr());
			else if (sel < 65) push_item(sc8_pkg::OPER_LOAD, d);
			else if (sel < 71) push_item(sc8_pkg::OPER_READ, d);
			else if (sel < 79) push_item(sc8_pkg::OPER_TICK, d);
			else if (sel < 88) push_item(sc8_pkg::OPER_KEY, d);
			else if (sel < 97) push_item(sc8_pkg::OPER_COLUMN, d);
			else push_item(($urandom_range(0, 1) == 0) ? OPER_SPARE_A : OPER_SPARE_B, d);
		end

		// exit at the current program counter, then execute while halted
		drain();
		load_word(last_pc, sc8_pkg::OPC_EXIT);
		repeat (2) push_item(sc8_pkg::OPER_EXEC, rand_fields());
		push_item(sc8_pkg::OPER_TICK, rand_fields());
		read_column(7'($urandom()));
		drain();
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("superchip8_instruction_core_top test passed");
		else
			$display("superchip8_instruction_core_top test failed");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("superchip8_instruction_core_top test failed");
		$finish;
	end
endmodule
